### rtl/core/bqf_pkg.sv
package bqf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 32;
  localparam int STATE_W  = 48;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 5;
  localparam int IDX_W    = ADDR_W - 2;

  typedef logic signed [SAMPLE_W-1:0] pcm_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [STATE_W-1:0]  state_t;
  typedef logic [IDX_W-1:0]           reg_idx_t;

  // coefficient register map, word index
  localparam reg_idx_t REG_B0 = 3'd0;
  localparam reg_idx_t REG_B1 = 3'd1;
  localparam reg_idx_t REG_B2 = 3'd2;
  localparam reg_idx_t REG_A1 = 3'd3;
  localparam reg_idx_t REG_A2 = 3'd4;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coef_set_t;

endpackage

### rtl/core/biquad_iir_filter_top.sv
// Channel   Handshake            Payload           Notes
// -------   ------------------   ---------------   ------------------------------
// in        in_valid / in_stall  sample_in  [15:0] signed PCM, one beat per sample
// out       out_valid/ out_stall sample_out [15:0] signed, saturated, one beat out
// cfg       APB psel/penable     paddr [4:0]       coef b0,b1,b2,a1,a2 at 0x0..0x10
//
// A sample runs through 13 sequencer steps after the idle state takes the beat;
// the next beat is taken only back in idle. The pace is set by the single 32x32
// multiplier, which runs each of the five products in two passes (low 32 and high
// 16 bits of the 48-bit operand), one product issued at steps 0, 2, 4, 6 and 8.
// rst is synchronous: coefficients return to b0 = 1.0, the rest 0, delays cleared.
// in_stall is high for the whole run. A held result parks the sequencer on its last
// step until out_stall drops; no new sample is taken meanwhile.
// A coefficient write clears both delays; a sequencer update in that cycle wins.
module biquad_iir_filter_top #(
  parameter int COEF_FRAC_BITS  = 27,
  parameter int STATE_FRAC_BITS = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bqf_pkg::pcm_t               sample_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bqf_pkg::pcm_t               sample_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bqf_pkg::ADDR_W-1:0]  paddr,
  input  logic [bqf_pkg::DATA_W-1:0]  pwdata,
  output logic [bqf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import bqf_pkg::*;

  coef_set_t coefs;
  logic      cfg_clr;
  logic      mul_issue;
  coef_t     mul_coef;
  state_t    mul_opnd;
  state_t    mul_term;

  // coefficient bank on the APB side
  bqf_regs #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs),
    .cfg_clr (cfg_clr)
  );

  // shared multiplier: |coef| x |operand|, rescale toward zero, clamp to 48 bits
  bqf_mul #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .issue (mul_issue),
    .coef  (mul_coef),
    .opnd  (mul_opnd),
    .term  (mul_term)
  );

  // step sequencer, accumulators, delay registers and output register
  bqf_seq #(
    .STATE_FRAC_BITS (STATE_FRAC_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .coefs      (coefs),
    .cfg_clr    (cfg_clr),
    .mul_issue  (mul_issue),
    .mul_coef   (mul_coef),
    .mul_opnd   (mul_opnd),
    .mul_term   (mul_term)
  );

endmodule

### rtl/core/bqf_mul.sv
module bqf_mul #(
  parameter int COEF_FRAC_BITS = 27
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            issue,
  input  bqf_pkg::coef_t  coef,
  input  bqf_pkg::state_t opnd,
  output bqf_pkg::state_t term
);
  import bqf_pkg::*;

  localparam int HALF_W = STATE_W - COEF_W;        // upper slice of the operand
  localparam int PROD_W = 2 * COEF_W;
  localparam int SUM_W  = COEF_W + STATE_W;
  localparam logic [SUM_W-1:0] POS_LIM = {{(SUM_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] NEG_LIM = POS_LIM + SUM_W'(1);

  logic [COEF_W-1:0]  cm;
  logic [COEF_W-1:0]  vl;
  logic [HALF_W-1:0]  vh;
  logic               sgn_a;
  logic               sgn_b;
  logic               lo_go;
  logic               hi_go;
  logic               comb_go;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  plo;

  logic [COEF_W-1:0]  cmag;
  logic [STATE_W-1:0] vmag;
  logic [COEF_W-1:0]  mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [SUM_W-1:0]   psum;
  logic [SUM_W-1:0]   pmag;
  logic [STATE_W-1:0] tmag;

  always_comb begin
    cmag  = coef[COEF_W-1] ? COEF_W'(-coef) : COEF_W'(coef);
    vmag  = opnd[STATE_W-1] ? STATE_W'(-opnd) : STATE_W'(opnd);
    mul_b = lo_go ? vl : {{(COEF_W-HALF_W){1'b0}}, vh};
    mul_p = cm * mul_b;
    // hi partial lands 32 bits up; hi product is below 2^STATE_W
    psum  = {prod[STATE_W-1:0], {COEF_W{1'b0}}} + {{(SUM_W-PROD_W){1'b0}}, plo};
    pmag  = psum >> COEF_FRAC_BITS;
    if (sgn_b) begin
      tmag = (pmag > NEG_LIM) ? NEG_LIM[STATE_W-1:0] : pmag[STATE_W-1:0];
    end else begin
      tmag = (pmag > POS_LIM) ? POS_LIM[STATE_W-1:0] : pmag[STATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_go   <= 1'b0;
      hi_go   <= 1'b0;
      comb_go <= 1'b0;
    end else begin
      lo_go   <= issue;
      hi_go   <= lo_go;
      comb_go <= hi_go;
    end

    if (issue) begin
      cm    <= cmag;
      vl    <= vmag[COEF_W-1:0];
      vh    <= vmag[STATE_W-1:COEF_W];
      sgn_a <= coef[COEF_W-1] ^ opnd[STATE_W-1];
    end
    if (lo_go || hi_go) begin
      prod <= mul_p;
    end
    if (hi_go) begin
      plo   <= prod;
      sgn_b <= sgn_a;
    end
    if (comb_go) begin
      term <= sgn_b ? state_t'(-tmag) : state_t'(tmag);
    end
  end

endmodule

### rtl/core/bqf_regs.sv
module bqf_regs #(
  parameter int COEF_FRAC_BITS = 27
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bqf_pkg::ADDR_W-1:0]   paddr,
  input  logic [bqf_pkg::DATA_W-1:0]   pwdata,
  output logic [bqf_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output bqf_pkg::coef_set_t           coefs,
  output logic                         cfg_clr
);
  import bqf_pkg::*;

  localparam coef_t B0_RESET = coef_t'(1) << COEF_FRAC_BITS;

  reg_idx_t idx;
  logic     wr;
  logic     idx_ok;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite && pready;
  assign idx_ok = (idx == REG_B0) || (idx == REG_B1) || (idx == REG_B2) ||
                  (idx == REG_A1) || (idx == REG_A2);
  // any coefficient write requests a flush of the delay line
  assign cfg_clr = wr && idx_ok;

  always_comb begin
    unique case (idx)
      REG_B0:  prdata = coefs.b0;
      REG_B1:  prdata = coefs.b1;
      REG_B2:  prdata = coefs.b2;
      REG_A1:  prdata = coefs.a1;
      REG_A2:  prdata = coefs.a2;
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.b0 <= B0_RESET;
      coefs.b1 <= '0;
      coefs.b2 <= '0;
      coefs.a1 <= '0;
      coefs.a2 <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_B0:  coefs.b0 <= coef_t'(pwdata);
        REG_B1:  coefs.b1 <= coef_t'(pwdata);
        REG_B2:  coefs.b2 <= coef_t'(pwdata);
        REG_A1:  coefs.a1 <= coef_t'(pwdata);
        REG_A2:  coefs.a2 <= coef_t'(pwdata);
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/bqf_seq.sv
module bqf_seq #(
  parameter int STATE_FRAC_BITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bqf_pkg::pcm_t       sample_in,
  output logic                out_valid,
  input  logic                out_stall,
  output bqf_pkg::pcm_t       sample_out,
  input  bqf_pkg::coef_set_t  coefs,
  input  logic                cfg_clr,
  output logic                mul_issue,
  output bqf_pkg::coef_t      mul_coef,
  output bqf_pkg::state_t     mul_opnd,
  input  bqf_pkg::state_t     mul_term
);
  import bqf_pkg::*;

  localparam int STEP_W = 4;
  localparam int ACC_W  = STATE_W + 2;

  // issue slots; each term is read in the accumulate slot in the same position below
  localparam logic [STEP_W-1:0] STEP_B0   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_B1   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_B2   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_A1   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_A2   = 4'd8;
  // accumulate slots
  localparam logic [STEP_W-1:0] STEP_Y    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_N1A  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_N2A  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_N1   = 4'd10;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd12;

  localparam logic signed [ACC_W-1:0] ST_MAX_X = {3'b000, {(STATE_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ST_MIN_X = {3'b111, {(STATE_W-1){1'b0}}};

  typedef enum logic {S_IDLE, S_RUN} seq_state_t;

  seq_state_t         state;
  logic [STEP_W-1:0]  step;
  state_t             xs;
  state_t             y;
  state_t             d1;
  state_t             d2;
  logic signed [ACC_W-1:0] acc1;
  state_t             acc2;

  logic signed [ACC_W-1:0] term_x;
  logic signed [ACC_W-1:0] y_sum;
  logic signed [ACC_W-1:0] n1a_sum;
  logic signed [ACC_W-1:0] n1_sum;
  logic signed [ACC_W-1:0] n2_sum;
  logic [STATE_W-1:0] yabs;
  logic [STATE_W-1:0] ysh;
  pcm_t               yout;
  logic               out_load;

  function automatic state_t sat_st(input logic signed [ACC_W-1:0] s);
    if (s > ST_MAX_X) begin
      return ST_MAX_X[STATE_W-1:0];
    end else if (s < ST_MIN_X) begin
      return ST_MIN_X[STATE_W-1:0];
    end else begin
      return s[STATE_W-1:0];
    end
  endfunction

  assign in_stall = (state != S_IDLE);
  // new result goes into the output register this edge
  assign out_load = (state == S_RUN) && (step == STEP_LAST) && (!out_valid || !out_stall);

  always_comb begin
    mul_issue = 1'b0;
    mul_coef  = coefs.b0;
    mul_opnd  = xs;
    if (state == S_RUN) begin
      case (step)
        STEP_B0: begin
          mul_issue = 1'b1;
        end
        STEP_B1: begin
          mul_issue = 1'b1;
          mul_coef  = coefs.b1;
        end
        STEP_B2: begin
          mul_issue = 1'b1;
          mul_coef  = coefs.b2;
        end
        STEP_A1: begin
          mul_issue = 1'b1;
          mul_coef  = coefs.a1;
          mul_opnd  = y;
        end
        STEP_A2: begin
          mul_issue = 1'b1;
          mul_coef  = coefs.a2;
          mul_opnd  = y;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    term_x  = {{2{mul_term[STATE_W-1]}}, mul_term};
    y_sum   = term_x + {{2{d1[STATE_W-1]}}, d1};
    n1a_sum = term_x + {{2{d2[STATE_W-1]}}, d2};
    n1_sum  = acc1 - term_x;
    n2_sum  = {{2{acc2[STATE_W-1]}}, acc2} - term_x;

    // integer part toward zero, clamped to the sample range
    yabs = y[STATE_W-1] ? STATE_W'(-y) : STATE_W'(y);
    ysh  = yabs >> STATE_FRAC_BITS;
    if (y[STATE_W-1]) begin
      yout = (ysh > STATE_W'(32768)) ? pcm_t'(16'h8000) : pcm_t'(-ysh[SAMPLE_W-1:0]);
    end else begin
      yout = (ysh > STATE_W'(32767)) ? pcm_t'(16'h7fff) : pcm_t'(ysh[SAMPLE_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
      d1        <= '0;
      d2        <= '0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      if (cfg_clr) begin
        d1 <= '0;
        d2 <= '0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            xs    <= STATE_W'(sample_in) <<< STATE_FRAC_BITS;
            step  <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          case (step)
            STEP_Y:   y    <= sat_st(y_sum);
            STEP_N1A: acc1 <= n1a_sum;
            STEP_N2A: acc2 <= mul_term;
            STEP_N1:  d1   <= sat_st(n1_sum);
            default: ;
          endcase
          if (step != STEP_LAST) begin
            step <= step + STEP_W'(1);
          end else if (!out_valid || !out_stall) begin
            d2         <= sat_st(n2_sum);
            sample_out <= yout;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sim/biquad_sample_checker.sv
`timescale 1ns / 100ps

// Watches the sample channels and the APB port of the biquad, keeps its own
// copy of the coefficients and delay line, and scores every output beat.
module biquad_sample_checker #(
  parameter int COEF_FRAC_BITS  = 27,
  parameter int STATE_FRAC_BITS = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  bqf_pkg::pcm_t              sample_in,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  bqf_pkg::pcm_t              sample_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bqf_pkg::ADDR_W-1:0] paddr,
  input  logic [bqf_pkg::DATA_W-1:0] pwdata,
  input  logic [bqf_pkg::DATA_W-1:0] prdata,
  input  logic                       pready,
  output int                         mismatch_count,
  output int                         expected_left,
  output int                         results_checked
);
  import bqf_pkg::*;

  localparam logic [95:0] POS_LIMIT = (96'd1 << (STATE_W - 1)) - 96'd1;
  localparam logic [95:0] NEG_LIMIT = 96'd1 << (STATE_W - 1);
  localparam longint      STATE_MAX = (longint'(1) << (STATE_W - 1)) - 1;
  localparam longint      STATE_MIN = -(longint'(1) << (STATE_W - 1));

  coef_set_t coefs;
  longint    delay_one;
  longint    delay_two;
  pcm_t      expected_samples[$];

  function automatic longint clamp_state(longint s);
    if (s > STATE_MAX) return STATE_MAX;
    if (s < STATE_MIN) return STATE_MIN;
    return s;
  endfunction

  // coef * v / 2^COEF_FRAC_BITS, toward zero, clamped to the state range
  function automatic longint scaled_product(coef_t c, longint v);
    logic        neg;
    logic [31:0] c_mag;
    logic [63:0] v_mag;
    logic [95:0] prod;
    logic [95:0] lim;
    neg   = (c < 0) != (v < 0);
    c_mag = c[COEF_W-1] ? -c : c;
    v_mag = (v < 0) ? -v : v;
    prod  = ({64'd0, c_mag} * {32'd0, v_mag}) >> COEF_FRAC_BITS;
    lim   = neg ? NEG_LIMIT : POS_LIMIT;
    if (prod > lim) prod = lim;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  // one sample through the section; advances the delay line
  function automatic pcm_t filter_sample(pcm_t x);
    longint xs;
    longint y;
    longint n1;
    longint n2;
    longint ym;
    xs = longint'(x) * (longint'(1) << STATE_FRAC_BITS);
    y  = clamp_state(scaled_product(coefs.b0, xs) + delay_one);
    n1 = clamp_state(scaled_product(coefs.b1, xs) - scaled_product(coefs.a1, y) + delay_two);
    n2 = clamp_state(scaled_product(coefs.b2, xs) - scaled_product(coefs.a2, y));
    delay_one = n1;
    delay_two = n2;
    ym = ((y < 0) ? -y : y) >> STATE_FRAC_BITS;
    if (y < 0) begin
      if (ym > 32768) ym = 32768;
      return pcm_t'(-ym);
    end
    if (ym > 32767) ym = 32767;
    return pcm_t'(ym);
  endfunction

  function automatic logic coef_at(reg_idx_t idx, output coef_t val);
    case (idx)
      REG_B0: val = coefs.b0;
      REG_B1: val = coefs.b1;
      REG_B2: val = coefs.b2;
      REG_A1: val = coefs.a1;
      REG_A2: val = coefs.a2;
      default: begin
        val = '0;
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    reg_idx_t idx;
    coef_t    cur;
    pcm_t     want;
    idx = paddr[ADDR_W-1:2];
    if (rst) begin
      coefs           = '{b0: coef_t'(1) <<< COEF_FRAC_BITS, default: '0};
      delay_one       = 0;
      delay_two       = 0;
      mismatch_count  = 0;
      results_checked = 0;
      expected_samples.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (idx)
            REG_B0: coefs.b0 = pwdata;
            REG_B1: coefs.b1 = pwdata;
            REG_B2: coefs.b2 = pwdata;
            REG_A1: coefs.a1 = pwdata;
            REG_A2: coefs.a2 = pwdata;
            default: ;
          endcase
          // unused addresses leave the delay line alone
          if (idx <= REG_A2) begin
            delay_one = 0;
            delay_two = 0;
          end
        end else if (coef_at(idx, cur) && prdata !== cur) begin
          $display("%t: readback of reg %0d, expected %h, got %h", $time, idx, cur, prdata);
          mismatch_count++;
        end
      end
      // retire the output beat before queuing this edge's input beat
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $display("%t: unexpected output beat, expected none, got %0d", $time, sample_out);
          mismatch_count++;
        end else begin
          want = expected_samples.pop_front();
          results_checked++;
          if (sample_out !== want) begin
            $display("%t: sample_out mismatch, expected %0d, got %0d", $time, want, sample_out);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_samples.push_back(filter_sample(sample_in));
    end
    expected_left = expected_samples.size();
  end

endmodule

### sim/tb_biquad_iir_filter_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the biquad section. All scoring lives in the
// checker instance; this module only drives the pins and reads its counters.
module tb_biquad_iir_filter_top;
  import bqf_pkg::*;

  localparam int COEF_FRAC  = 27;
  localparam int STATE_FRAC = 20;
  // worst gap between beats: sender gap + sequencer run + output stall
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 40;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_SAMPLES  = 50;

  localparam coef_t ONE     = coef_t'(1) <<< COEF_FRAC;
  localparam coef_t HALF    = coef_t'(1) <<< (COEF_FRAC - 1);
  localparam coef_t COEF_HI = 32'sh7FFF_FFFF;
  localparam coef_t COEF_LO = 32'sh8000_0000;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  pcm_t              sample_in;
  logic              out_valid;
  logic              out_stall;
  pcm_t              sample_out;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int   mismatch_count;
  int   expected_left;
  int   results_checked;
  int   samples_sent = 0;
  int   cfg_writes   = 0;
  int   quiet_cycles = 0;
  // when low both sides run flat out
  logic idle_on      = 1'b1;

  always #5 clk = ~clk;

  biquad_iir_filter_top #(
    .COEF_FRAC_BITS (COEF_FRAC),
    .STATE_FRAC_BITS(STATE_FRAC)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample_out(sample_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  biquad_sample_checker #(
    .COEF_FRAC_BITS (COEF_FRAC),
    .STATE_FRAC_BITS(STATE_FRAC)
  ) scoreboard (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample_in      (sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sample_out     (sample_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .expected_left  (expected_left),
    .results_checked(results_checked)
  );

  // Watchdog: any beat on any port resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%t: watchdog, no beat for %0d cycles", $time, quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Output side: per result, a random stall if idling is on, then take the beat.
  initial begin
    int hold;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      hold = idle_on ? $urandom_range(0, 8) : 0;
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // --- APB helpers: setup cycle, then access until pready ---
  task automatic cfg_write(reg_idx_t idx, logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_writes++;
  endtask

  // checker compares prdata against its own register copy
  task automatic cfg_read(reg_idx_t idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_all_coefs();
    for (int r = REG_B0; r <= REG_A2; r++)
      cfg_read(reg_idx_t'(r));
  endtask

  task automatic load_coefs(coef_t b0, coef_t b1, coef_t b2, coef_t a1, coef_t a2);
    cfg_write(REG_B0, b0);
    cfg_write(REG_B1, b1);
    cfg_write(REG_B2, b2);
    cfg_write(REG_A1, a1);
    cfg_write(REG_A2, a2);
  endtask

  // writes past the register list must not touch coefficients or delays
  task automatic poke_unused_addrs();
    for (int r = int'(REG_A2) + 1; r < (1 << IDX_W); r++)
      cfg_write(reg_idx_t'(r), $urandom);
  endtask

  // one input beat, preceded by a random gap when idling is on
  task automatic push_sample(pcm_t x);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  // park the sender until every queued result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_left != 0) @(negedge clk);
  endtask

  function automatic pcm_t rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return pcm_t'($urandom_range(0, 64)) - 16'sd32;
      default: return pcm_t'($urandom);
    endcase
  endfunction

  // style 0: moderate gains within +-2.0; 1: any 32-bit value; 2: corner values
  function automatic coef_t rand_coef(int style);
    case (style)
      0: return coef_t'($urandom_range(0, 1 << 29)) - (coef_t'(1) <<< 28);
      1: return coef_t'($urandom);
      default: begin
        case ($urandom_range(0, 6))
          0:       return COEF_HI;
          1:       return COEF_LO;
          2:       return ONE;
          3:       return -ONE;
          4:       return coef_t'(1);
          5:       return -coef_t'(1);
          default: return '0;
        endcase
      end
    endcase
  endfunction

  initial begin
    int style;
    rst       = 1'b1;
    in_valid  = 1'b0;
    sample_in = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset coefficients are a pure pass-through: y == x.
    read_all_coefs();
    push_sample(16'sd0);
    push_sample(16'sd1);
    push_sample(-16'sd1);
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sh5555);
    push_sample(16'shAAAA);
    push_sample(16'sd12345);

    // All coefficients at full scale: products and sums hit the 48-bit rails,
    // output saturates both ways. Run flat out here.
    drain_results();
    idle_on = 1'b0;
    load_coefs(COEF_HI, COEF_LO, COEF_HI, COEF_LO, COEF_HI);
    read_all_coefs();
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    push_sample(16'sd0);
    push_sample(-16'sd1);

    // Gain of one half: odd inputs land on .5 and must truncate toward zero.
    drain_results();
    idle_on = 1'b1;
    load_coefs(HALF, '0, '0, '0, '0);
    push_sample(-16'sd1);
    push_sample(16'sd1);
    push_sample(-16'sd3);
    push_sample(16'sd3);

    // Resonant low-pass; the delay line must survive unused-address writes.
    drain_results();
    load_coefs(32'sd13421773, 32'sd26843546, 32'sd13421773, -32'sd255013683, 32'sd127506842);
    push_sample(16'sd20000);
    push_sample(16'sd20000);
    push_sample(-16'sd20000);
    push_sample(16'sd5000);
    drain_results();
    poke_unused_addrs();
    push_sample(16'sd0);
    push_sample(16'sd0);
    push_sample(16'sd1000);
    push_sample(-16'sd1000);

    // Random phases. Each starts drained (sender pause with nothing in flight),
    // reprograms some coefficients, reads them back, then streams samples.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_results();
      idle_on = (ph % 3) != 2;
      style   = ph % 3;
      for (int r = REG_B0; r <= REG_A2; r++)
        if (ph < 2 || $urandom_range(0, 3) != 0)
          cfg_write(reg_idx_t'(r), rand_coef(style));
      if (ph % 3 == 1)
        poke_unused_addrs();
      read_all_coefs();
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        push_sample(rand_sample());
        // mid-phase pause: the delay line must carry over an idle stretch
        if (ph == 3 && i == PHASE_SAMPLES / 2)
          drain_results();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d samples, %0d register writes, %0d results scored;",
             samples_sent, cfg_writes, results_checked);
    $display("pass-through, full-scale rails, truncation, resonance, unused addresses.");
    if (mismatch_count == 0 && expected_left == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### sim.f
rtl/core/bqf_pkg.sv
rtl/core/bqf_mul.sv
rtl/core/bqf_regs.sv
rtl/core/bqf_seq.sv
rtl/core/biquad_iir_filter_top.sv
sim/biquad_sample_checker.sv
sim/tb_biquad_iir_filter_top.sv
